FILE: rtl/core/epd_pkg.sv
// Package for the escaped packet deframer.
// Holds the framing codes, event kinds and the structs passed between stages.
// No dependencies.
package epd_pkg;

  localparam logic [7:0] ESC_CODE   = 8'h1B;
  localparam logic [7:0] START_CODE = 8'h01;
  localparam logic [7:0] END_CODE   = 8'h04;
  localparam logic [7:0] NO_OPCODE  = 8'hFF;
  localparam logic [8:0] COUNT_MAX  = 9'd511;

  typedef enum logic [2:0] {
    EV_PAYLOAD = 3'd0,
    EV_GOOD    = 3'd1,
    EV_BAD     = 3'd2,
    EV_BAD_ESC = 3'd3,
    EV_OVERRUN = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } step_t;

  typedef struct packed {
    logic        valid;
    event_kind_t kind;
    logic [7:0]  payload;
    logic [7:0]  opcode;
  } result_t;

endpackage

FILE: rtl/core/epd_in_if.sv
// Receive byte channel of the escaped packet deframer.
// Valid/ready handshake carrying one received byte per transaction.
interface epd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/core/epd_out_if.sv
// Event channel of the escaped packet deframer.
// Valid/ready handshake carrying one decoded event per transaction.
interface epd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] payload_byte;
  logic [7:0] frame_opcode;

  modport source (output valid, output event_kind, output payload_byte,
                  output frame_opcode, input ready);
  modport sink (input valid, input event_kind, input payload_byte,
                input frame_opcode, output ready);
endinterface

FILE: rtl/core/epd_in_stage.sv
// Input register of the escaped packet deframer.
// Depends on epd_pkg and epd_in_if.
module epd_in_stage (
  input  logic           clk,
  input  logic           rst,
  epd_in_if.sink         rx,
  input  logic           take,
  output epd_pkg::step_t step
);

  logic       valid;
  logic [7:0] data;

  assign rx.ready = !valid || take;
  assign step.valid = valid;
  assign step.data = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      data <= rx.rx_byte;
    end
  end

endmodule

FILE: rtl/core/epd_decode.sv
// Frame decoder of the escaped packet deframer: framing state and per-byte update.
// Depends on epd_pkg.
module epd_decode (
  input  logic             clk,
  input  logic             rst,
  input  epd_pkg::step_t   step,
  input  logic             out_free,
  output logic             take,
  output epd_pkg::result_t res
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SIZE = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  phase_t     phase, phase_next;
  logic       esc_pending, esc_pending_next;
  logic [7:0] size, size_next;
  logic [8:0] byte_count, byte_count_next;
  logic [7:0] sum, sum_next;
  logic [7:0] opcode, opcode_next;
  logic       opcode_seen, opcode_seen_next;

  epd_pkg::result_t ev;
  logic [7:0]       b;
  logic             body;
  logic [8:0]       size_ext;
  logic [9:0]       count_add;
  logic [1:0]       weight;
  logic             good;

  assign b = step.data;
  assign body = (phase == PH_BODY);
  assign size_ext = {1'b0, size};
  assign good = (byte_count == size_ext + 9'd1) && (sum == 8'd0);

  always_comb begin
    weight = (b == epd_pkg::ESC_CODE) ? 2'd2 : 2'd1;
    count_add = {1'b0, byte_count} + {8'd0, weight};
  end

  always_comb begin
    phase_next = phase;
    esc_pending_next = esc_pending;
    size_next = size;
    byte_count_next = byte_count;
    sum_next = sum;
    opcode_next = opcode;
    opcode_seen_next = opcode_seen;
    ev = '0;
    ev.kind = epd_pkg::EV_PAYLOAD;

    if (phase == PH_SIZE) begin
      size_next = b;
      sum_next = b;
      byte_count_next = '0;
      phase_next = PH_BODY;
    end else if (esc_pending) begin
      esc_pending_next = 1'b0;
      if (b == epd_pkg::START_CODE) begin
        phase_next = PH_SIZE;
        size_next = '0;
        byte_count_next = '0;
        sum_next = epd_pkg::NO_OPCODE;
        opcode_next = epd_pkg::NO_OPCODE;
        opcode_seen_next = 1'b0;
      end else if (body) begin
        if (b == epd_pkg::ESC_CODE) begin
          sum_next = sum + b;
          byte_count_next = (count_add > {1'b0, epd_pkg::COUNT_MAX}) ?
                            epd_pkg::COUNT_MAX : count_add[8:0];
          if (!opcode_seen) begin
            opcode_next = b;
            opcode_seen_next = 1'b1;
          end
          ev.valid = 1'b1;
          ev.payload = b;
        end else begin
          phase_next = PH_IDLE;
          size_next = '0;
          byte_count_next = '0;
          sum_next = epd_pkg::NO_OPCODE;
          opcode_next = epd_pkg::NO_OPCODE;
          opcode_seen_next = 1'b0;
          ev.valid = 1'b1;
          if (b == epd_pkg::END_CODE) begin
            if (good) begin
              ev.kind = epd_pkg::EV_GOOD;
              ev.opcode = opcode;
            end else begin
              ev.kind = epd_pkg::EV_BAD;
            end
          end else begin
            ev.kind = epd_pkg::EV_BAD_ESC;
          end
        end
      end
    end else if (b == epd_pkg::ESC_CODE) begin
      esc_pending_next = 1'b1;
    end else if (body) begin
      if (byte_count > size_ext) begin
        phase_next = PH_IDLE;
        size_next = '0;
        byte_count_next = '0;
        sum_next = epd_pkg::NO_OPCODE;
        opcode_next = epd_pkg::NO_OPCODE;
        opcode_seen_next = 1'b0;
        ev.valid = 1'b1;
        ev.kind = epd_pkg::EV_OVERRUN;
      end else begin
        // checksum byte when the count has reached the size, payload below it
        sum_next = sum + b;
        byte_count_next = (count_add > {1'b0, epd_pkg::COUNT_MAX}) ?
                          epd_pkg::COUNT_MAX : count_add[8:0];
        if (byte_count != size_ext) begin
          if (!opcode_seen) begin
            opcode_next = b;
            opcode_seen_next = 1'b1;
          end
          ev.valid = 1'b1;
          ev.payload = b;
        end
      end
    end
  end

  assign take = step.valid && (!ev.valid || out_free);

  always_comb begin
    res = ev;
    res.valid = take && ev.valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      esc_pending <= 1'b0;
      size <= '0;
      byte_count <= '0;
      sum <= epd_pkg::NO_OPCODE;
      opcode <= epd_pkg::NO_OPCODE;
      opcode_seen <= 1'b0;
    end else if (take) begin
      unique case (phase_next)
        PH_IDLE, PH_SIZE, PH_BODY: phase <= phase_next;
        default: phase <= PH_IDLE;
      endcase
      esc_pending <= esc_pending_next;
      size <= size_next;
      byte_count <= byte_count_next;
      sum <= sum_next;
      opcode <= opcode_next;
      opcode_seen <= opcode_seen_next;
    end
  end

`ifndef SYNTHESIS
  a_size_to_body: assert property (@(posedge clk) disable iff (rst)
    take && phase == PH_SIZE |=> phase == PH_BODY && byte_count == 9'd0)
    else $error("size byte did not open the frame body");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind != epd_pkg::EV_PAYLOAD |=> phase == PH_IDLE && !opcode_seen)
    else $error("frame end or abort left frame state behind");

  a_opcode_reset: assert property (@(posedge clk) disable iff (rst)
    !opcode_seen |-> opcode == epd_pkg::NO_OPCODE)
    else $error("opcode captured without opcode_seen");

  a_result_needs_byte: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> step.valid && out_free)
    else $error("event produced without a byte or a free output slot");
`endif

endmodule

FILE: rtl/core/epd_out_stage.sv
// Output register of the escaped packet deframer.
// Depends on epd_pkg and epd_out_if.
module epd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  epd_pkg::result_t res,
  output logic             out_free,
  epd_out_if.source        ev
);

  logic             valid;
  epd_pkg::result_t data;

  assign out_free = !valid || ev.ready;
  assign ev.valid = valid;
  assign ev.event_kind = data.kind;
  assign ev.payload_byte = data.payload;
  assign ev.frame_opcode = data.opcode;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res.valid) begin
      valid <= 1'b1;
    end else if (ev.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      data <= res;
    end
  end

endmodule

FILE: rtl/core/escaped_packet_deframer.sv
// Top level of the escaped packet deframer.
// Depends on epd_pkg, epd_in_if, epd_out_if, epd_in_stage, epd_decode, epd_out_stage.
//
// Recognizes byte-stuffed frames (ESC 0x01 start, size byte, body, ESC 0x04
// end, ESC ESC for a literal 0x1B) and emits one event per payload byte plus
// a good/bad/abort event at frame end. Each received byte is decoded
// combinationally between the input register and the event register, so one
// byte is accepted every cycle; a stall on the event side stops intake only
// when a byte that makes an event meets a full event register. A byte passes
// the input register and then the event register on its way to its event.
module escaped_packet_deframer (
  input  logic      clk,
  input  logic      rst,
  epd_in_if.sink    rx,
  epd_out_if.source events
);

  epd_pkg::step_t   step;
  epd_pkg::result_t res;
  logic             take;
  logic             out_free;

  epd_in_stage u_in (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .take (take),
    .step (step)
  );

  epd_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .out_free (out_free),
    .take     (take),
    .res      (res)
  );

  epd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .out_free (out_free),
    .ev       (events)
  );

endmodule

FILE: test/tb_escaped_packet_deframer.sv
// Testbench for escaped_packet_deframer: directed and random byte streams, mostly
// well-formed frames with corrupted ones mixed in, checked against a scoreboard.
// Depends on epd_pkg, epd_in_if, epd_out_if and the deframer RTL.
module tb_escaped_packet_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned IDLE_PCT     = 13;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SIZE = 2'd1,
    PH_BODY = 2'd2
  } frame_phase_t;

  typedef struct {
    epd_pkg::event_kind_t kind;
    logic [7:0]           payload;
    logic [7:0]           opcode;
  } frame_event_t;

  class frame_event_scoreboard;
    frame_phase_t phase;
    bit           esc_pending;
    logic [7:0]   size;
    logic [8:0]   count;
    logic [7:0]   sum;
    logic [7:0]   opcode;
    bit           opcode_seen;
    frame_event_t expected_events[$];
    int unsigned  errors;

    function new();
      esc_pending = 1'b0;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      phase = PH_IDLE;
      size = 8'h00;
      count = 9'd0;
      sum = epd_pkg::NO_OPCODE;
      opcode = epd_pkg::NO_OPCODE;
      opcode_seen = 1'b0;
    endfunction

    function void add_count(logic [1:0] n);
      logic [9:0] c;
      c = {1'b0, count} + {8'd0, n};
      count = (c > {1'b0, epd_pkg::COUNT_MAX}) ? epd_pkg::COUNT_MAX : c[8:0];
    endfunction

    function void take_data(logic [7:0] b, logic [1:0] weight, output frame_event_t ev);
      sum = sum + b;
      add_count(weight);
      if (!opcode_seen) begin
        opcode = b;
        opcode_seen = 1'b1;
      end
      ev = '{epd_pkg::EV_PAYLOAD, b, 8'h00};
    endfunction

    // Advances the deframer state by one byte; returns 1 when an event results.
    function bit decode_byte(logic [7:0] b, output frame_event_t ev);
      bit         in_body;
      bit         good;
      logic [7:0] op;
      in_body = (phase == PH_BODY);
      ev = '{epd_pkg::EV_PAYLOAD, 8'h00, 8'h00};
      if (phase == PH_SIZE) begin
        size = b;
        sum = b;
        count = 9'd0;
        phase = PH_BODY;
        return 1'b0;
      end
      if (esc_pending) begin
        esc_pending = 1'b0;
        if (b == epd_pkg::START_CODE) begin
          clear_frame();
          phase = PH_SIZE;
          return 1'b0;
        end
        if (!in_body) return 1'b0;
        if (b == epd_pkg::ESC_CODE) begin
          take_data(b, 2'd2, ev);
          return 1'b1;
        end
        if (b == epd_pkg::END_CODE) begin
          good = (count == {1'b0, size} + 9'd1) && (sum == 8'h00);
          op = opcode;
          clear_frame();
          if (good) begin
            ev.kind = epd_pkg::EV_GOOD;
            ev.opcode = op;
          end else begin
            ev.kind = epd_pkg::EV_BAD;
          end
          return 1'b1;
        end
        clear_frame();
        ev.kind = epd_pkg::EV_BAD_ESC;
        return 1'b1;
      end
      if (b == epd_pkg::ESC_CODE) begin
        esc_pending = 1'b1;
        return 1'b0;
      end
      if (!in_body) return 1'b0;
      if (count > {1'b0, size}) begin
        clear_frame();
        ev.kind = epd_pkg::EV_OVERRUN;
        return 1'b1;
      end
      if (count == {1'b0, size}) begin
        // checksum byte: summed and counted, not emitted
        sum = sum + b;
        add_count(2'd1);
        return 1'b0;
      end
      take_data(b, 2'd1, ev);
      return 1'b1;
    endfunction

    function void note_byte(logic [7:0] b);
      frame_event_t ev;
      if (decode_byte(b, ev)) expected_events.push_back(ev);
    endfunction

    function void check_event(logic [2:0] kind, logic [7:0] payload, logic [7:0] op);
      frame_event_t exp;
      if (expected_events.size() == 0) begin
        $error("event with none expected: event_kind %0d payload_byte %02h frame_opcode %02h",
               kind, payload, op);
        errors++;
        return;
      end
      exp = expected_events.pop_front();
      if (kind !== exp.kind) begin
        $error("event_kind: expected %0d, got %0d", exp.kind, kind);
        errors++;
      end
      if (payload !== exp.payload) begin
        $error("payload_byte: expected %02h, got %02h", exp.payload, payload);
        errors++;
      end
      if (op !== exp.opcode) begin
        $error("frame_opcode: expected %02h, got %02h", exp.opcode, op);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   no_idle;
  int unsigned cycle_count;

  epd_in_if  rx_if ();
  epd_out_if ev_if ();

  frame_event_scoreboard sb = new();

  escaped_packet_deframer dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_if),
    .events (ev_if)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_escaped_packet_deframer: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    ev_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rx_if.valid && rx_if.ready) sb.note_byte(rx_if.rx_byte);
      if (ev_if.valid && ev_if.ready)
        sb.check_event(ev_if.event_kind, ev_if.payload_byte, ev_if.frame_opcode);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      rx_if.valid <= 1'b0;
      @(negedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [7:0]  directed_bytes[$];
    logic [7:0]  wire_q[$];
    logic [7:0]  b;
    logic [7:0]  csum;
    int unsigned size;
    int unsigned filled;
    int unsigned mode;
    int unsigned pick;
    int unsigned frame_no;
    int unsigned frame_items;

    directed_bytes = '{
      8'hFF, 8'h00, epd_pkg::ESC_CODE, 8'h07,                     // ignored outside a frame
      epd_pkg::ESC_CODE, epd_pkg::START_CODE, 8'h00, 8'h00,
      epd_pkg::ESC_CODE, epd_pkg::END_CODE,                       // empty good frame
      epd_pkg::ESC_CODE, epd_pkg::START_CODE, epd_pkg::ESC_CODE,
      8'h05,                                                      // size byte equal to ESC
      epd_pkg::ESC_CODE, epd_pkg::START_CODE, 8'h01, epd_pkg::ESC_CODE,
      epd_pkg::ESC_CODE, 8'h00,                                   // restart, then overrun
      epd_pkg::ESC_CODE, epd_pkg::START_CODE, 8'h00, epd_pkg::ESC_CODE,
      epd_pkg::END_CODE,                                          // missing checksum
      epd_pkg::ESC_CODE, epd_pkg::START_CODE, 8'h02, epd_pkg::ESC_CODE,
      8'h33                                                       // unknown escape
    };

    rst = 1'b1;
    no_idle = 1'b0;
    cycle_count = 0;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = 8'h00;
    ev_if.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    frame_no = 0;
    frame_items = 0;
    while (frame_items < RANDOM_ITEMS) begin
      no_idle = (frame_no >= 40 && frame_no < 60);
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));

      pick = $urandom_range(0, 99);
      if (pick < 1) size = $urandom_range(200, 255);
      else if (pick < 9) size = $urandom_range(16, 63);
      else size = $urandom_range(0, 15);

      wire_q = '{epd_pkg::ESC_CODE, epd_pkg::START_CODE, size[7:0]};
      csum = size[7:0];
      filled = 0;
      while (filled < size) begin
        b = ($urandom_range(0, 9) == 0) ? epd_pkg::ESC_CODE : 8'($urandom_range(0, 255));
        if (b == epd_pkg::ESC_CODE && filled + 2 > size) b = 8'($urandom_range(0, 8'h1A));
        if (b == epd_pkg::ESC_CODE) begin
          wire_q.push_back(epd_pkg::ESC_CODE);
          wire_q.push_back(epd_pkg::ESC_CODE);
          filled += 2;
        end else begin
          wire_q.push_back(b);
          filled++;
        end
        csum = csum + b;
      end
      csum = 8'h00 - csum;

      mode = $urandom_range(0, 99);
      if (mode < 70) begin
        wire_q.push_back(csum);
      end else if (mode < 78) begin
        if ($urandom_range(0, 1)) wire_q.push_back(csum + 8'($urandom_range(1, 255)));
      end else if (mode < 86) begin
        wire_q.push_back(csum);
        repeat ($urandom_range(1, 3)) wire_q.push_back(8'($urandom_range(0, 8'h1A)));
      end else if (mode < 93) begin
        do b = 8'($urandom_range(0, 255));
        while (b == epd_pkg::ESC_CODE || b == epd_pkg::START_CODE ||
               b == epd_pkg::END_CODE);
        wire_q.push_back(epd_pkg::ESC_CODE);
        wire_q.push_back(b);
      end else begin
        // restart into an empty frame
        wire_q.push_back(epd_pkg::ESC_CODE);
        wire_q.push_back(epd_pkg::START_CODE);
        wire_q.push_back(8'h00);
        wire_q.push_back(8'h00);
      end
      wire_q.push_back(epd_pkg::ESC_CODE);
      wire_q.push_back(epd_pkg::END_CODE);

      foreach (wire_q[i]) send_byte(wire_q[i]);
      frame_items += wire_q.size();
      frame_no++;
    end
    rx_if.valid <= 1'b0;

    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (sb.expected_events.size() != 0)
      $error("%0d expected events never arrived", sb.expected_events.size());
    if (sb.errors == 0 && sb.expected_events.size() == 0) begin
      $display("tb_escaped_packet_deframer: clean");
    end else begin
      $display("tb_escaped_packet_deframer: errors");
    end
    $finish;
  end

endmodule
